// ===== rtl/psmpx_pkg.sv =====
package psmpx_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd4;

  // Field widths
  localparam int AUDIO_W = 16;
  localparam int GAIN_W  = 15;
  localparam int STEP_W  = 32;
  localparam int SUM_W   = 17;
  localparam int DIFF_W  = 18;

  // Register defaults
  localparam logic [GAIN_W-1:0]         CLIP_LEVEL_RST   = 15'd17203;
  localparam logic [GAIN_W-1:0]         MONO_GAIN_RST    = 15'd14746;
  localparam logic [GAIN_W-1:0]         STEREO_GAIN_RST  = 15'd14746;
  localparam logic signed [AUDIO_W-1:0] PILOT_OFFSET_RST = 16'sd6554;
  localparam logic [STEP_W-1:0]         PHASE_STEP_RST   = 32'd699050667;

  // Radix-4 steps per multiplier pass
  localparam int GAIN_DIGITS = (GAIN_W + 1) / 2;
  localparam int DIFF_DIGITS = DIFF_W / 2;
  localparam int CNT_W       = 4;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctl_t;

  // Quarter-wave sine magnitude, entry j of a 2^tbits table, amplitude 2^(sbits-1)-1.
  // Taylor series in Q30, evaluated at elaboration only.
  function automatic logic [63:0] sine_mag(input int j, input int tbits, input int sbits);
    logic [63:0] amp;
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] mag;
    amp = (64'd1 << (sbits - 1)) - 64'd1;
    one = 64'd1 << 30;
    x   = (TWO_PI_Q30 * 64'(j)) >> tbits;
    x2  = (x * x) >> 30;
    acc = one;
    acc = one - ((x2 * acc) >> 30) / 64'd156;
    acc = one - ((x2 * acc) >> 30) / 64'd110;
    acc = one - ((x2 * acc) >> 30) / 64'd72;
    acc = one - ((x2 * acc) >> 30) / 64'd42;
    acc = one - ((x2 * acc) >> 30) / 64'd20;
    acc = one - ((x2 * acc) >> 30) / 64'd6;
    s   = (x * acc) >> 30;
    mag = (s * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return mag;
  endfunction

endpackage

// ===== rtl/psmpx_serial_mul.sv =====
// Radix-4 shift-add multiplier: two multiplier bits retire per step.
module psmpx_serial_mul #(
  parameter int ACC_W    = 32,
  parameter int MPLIER_W = 16
) (
  input  logic                        clk,
  input  psmpx_pkg::mul_ctl_t         ctl,
  input  logic signed [ACC_W-1:0]     init_acc,
  input  logic signed [ACC_W-1:0]     mcand,
  input  logic        [MPLIER_W-1:0]  mplier,
  output logic signed [ACC_W-1:0]     acc
);
  import psmpx_pkg::*;

  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    mcand_r, mcand_nxt;
  logic        [MPLIER_W-1:0] mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0]    pp0, pp1;

  always_comb begin
    pp0        = mplier_r[0] ? mcand_r : '0;
    pp1        = mplier_r[1] ? (mcand_r <<< 1) : '0;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (ctl.load) begin
      acc_nxt    = init_acc;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
    end else if (ctl.step) begin
      acc_nxt    = acc_r + pp0 + pp1;
      mcand_nxt  = mcand_r <<< 2;
      mplier_nxt = mplier_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/polar_stereo_mpx_encoder_core.sv =====
// A request is taken only in idle; the block then runs two radix-4 shift-add passes
// (8 steps for the gain products, 9 steps for the difference product) and takes
// no new request until the result has moved to the output register.
// A finished sample waits in the output register while the next one is computed.
// Reset (rst_n low, synchronous): registers return to their defaults, the carrier
// phase clears to zero and no result is pending.
module polar_stereo_mpx_encoder_core #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // [15:0] left_sample, [31:16] right_sample
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,  // [15:0] mpx_sample
  // configuration writes
  input  logic                                cfg_we,
  input  logic [psmpx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psmpx_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import psmpx_pkg::*;

  // Sine table geometry: quarter wave plus the peak entry
  localparam int STB     = SINE_TABLE_BITS;
  localparam int SB      = SAMPLE_BITS;
  localparam int QUARTER = 1 << (STB - 2);
  localparam int J_W     = STB - 1;
  localparam int MAG_W   = SB - 1;

  // Datapath widths
  localparam int CAR_W   = SB;        // carrier, signed
  localparam int P_W     = SB + 16;   // carrier * stereo_gain
  localparam int Q_W     = 33;        // (L+R) * mono_gain
  localparam int B_W     = SB + 34;   // full composite accumulator
  localparam int SHIFT   = SB + 15;   // back to Q1.15
  localparam int OUT_Q_W = B_W - SHIFT;

  localparam logic [B_W-1:0]            ROUND_B  = B_W'(1) << (SHIFT - 1);
  localparam logic signed [OUT_Q_W-1:0] Q_MAX    = OUT_Q_W'(32767);
  localparam logic signed [OUT_Q_W-1:0] Q_MIN    = -OUT_Q_W'(32768);
  localparam logic signed [CAR_W-1:0]   CAR_MAX  = CAR_W'((1 << (SB - 1)) - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_MULA = 6'b000100,
    ST_LDB  = 6'b001000,
    ST_MULB = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration and control state
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]          clip_r, mono_gain_r, stereo_gain_r;
  logic signed [AUDIO_W-1:0]  pilot_r;
  logic [STEP_W-1:0]          phase_step_r;
  logic [PHASE_BITS-1:0]      carrier_phase_r, carrier_phase_nxt, phase_sum;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Item payload
  logic signed [AUDIO_W-1:0]  left_r, right_r;
  logic signed [CAR_W-1:0]    carrier_r;
  logic                       d_neg_r;
  logic [DIFF_W-1:0]          d_mag_r;
  logic [15:0]                out_data_r;

  logic in_acc;
  logic load_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign load_out   = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------------------
  // Subcarrier: phase accumulator and quarter-wave sine table
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] rom_tab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    localparam logic [63:0] ENTRY = sine_mag(g, STB, SB);
    assign rom_tab[g] = ENTRY[MAG_W-1:0];
  end

  logic [STB-1:0]           rom_k;
  logic [J_W-1:0]           rom_kh, rom_j;
  logic signed [CAR_W-1:0]  rom_mag_ext, rom_carrier;

  always_comb begin
    rom_k  = carrier_phase_r[PHASE_BITS-1 -: STB];
    rom_kh = rom_k[STB-2:0];
    // second quarter mirrors: half - k, which is -k modulo the quarter index width
    rom_j  = (rom_kh > J_W'(QUARTER)) ? (J_W'(0) - rom_kh) : rom_kh;
    rom_mag_ext = $signed({1'b0, rom_tab[rom_j]});
    rom_carrier = rom_k[STB-1] ? -rom_mag_ext : rom_mag_ext;
  end

  assign phase_sum         = carrier_phase_r + PHASE_BITS'(phase_step_r);
  assign carrier_phase_nxt = in_acc ? phase_sum : carrier_phase_r;

  // ---------------------------------------------------------------------------
  // Clip, sum and difference
  // ---------------------------------------------------------------------------
  function automatic logic signed [AUDIO_W-1:0] clip_s(input logic signed [AUDIO_W-1:0] s,
                                                       input logic [GAIN_W-1:0] lim);
    logic signed [AUDIO_W-1:0] t;
    t = $signed({1'b0, lim});
    if (s > t) return t;
    if (s < -t) return -t;
    return s;
  endfunction

  logic signed [AUDIO_W-1:0] l_c, r_c;
  logic signed [SUM_W-1:0]   sum_c;
  logic signed [DIFF_W-1:0]  diff_c;

  always_comb begin
    l_c    = clip_s(left_r, clip_r);
    r_c    = clip_s(right_r, clip_r);
    sum_c  = SUM_W'(l_c) + SUM_W'(r_c);
    // L - R + 2*pilot, all at 2^-16
    diff_c = DIFF_W'(l_c) - DIFF_W'(r_c) + (DIFF_W'(pilot_r) <<< 1);
  end

  // ---------------------------------------------------------------------------
  // Multipliers: carrier*stereo_gain and sum*mono_gain run together,
  // then the difference times that product accumulates onto the mono term.
  // ---------------------------------------------------------------------------
  mul_ctl_t ctl_a, ctl_b;
  assign ctl_a = '{load: (state_r == ST_PREP), step: (state_r == ST_MULA)};
  assign ctl_b = '{load: (state_r == ST_LDB),  step: (state_r == ST_MULB)};

  logic signed [P_W-1:0] p_acc;
  logic signed [Q_W-1:0] q_acc;
  logic signed [B_W-1:0] t_acc, p_ext, b_mcand, b_init;

  psmpx_serial_mul #(.ACC_W(P_W), .MPLIER_W(GAIN_W)) u_mul_p (
    .clk      (clk),
    .ctl      (ctl_a),
    .init_acc ('0),
    .mcand    (P_W'(carrier_r)),
    .mplier   (stereo_gain_r),
    .acc      (p_acc)
  );

  psmpx_serial_mul #(.ACC_W(Q_W), .MPLIER_W(GAIN_W)) u_mul_q (
    .clk      (clk),
    .ctl      (ctl_a),
    .init_acc ('0),
    .mcand    (Q_W'(sum_c)),
    .mplier   (mono_gain_r),
    .acc      (q_acc)
  );

  always_comb begin
    p_ext   = B_W'(p_acc);
    b_mcand = d_neg_r ? -p_ext : p_ext;
    // mono term lifted by 2^(SB-1), plus half an output LSB for rounding
    b_init  = (B_W'(q_acc) <<< (SB - 1)) + $signed(ROUND_B);
  end

  psmpx_serial_mul #(.ACC_W(B_W), .MPLIER_W(DIFF_W)) u_mul_t (
    .clk      (clk),
    .ctl      (ctl_b),
    .init_acc (b_init),
    .mcand    (b_mcand),
    .mplier   (d_mag_r),
    .acc      (t_acc)
  );

  // Floor shift gives round-half-up after the bias; then saturate
  logic signed [OUT_Q_W-1:0] q_full;
  logic [15:0]               q_sat;

  always_comb begin
    q_full = t_acc[B_W-1:SHIFT];
    if (q_full > Q_MAX) begin
      q_sat = 16'h7FFF;
    end else if (q_full < Q_MIN) begin
      q_sat = 16'h8000;
    end else begin
      q_sat = q_full[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = ST_MULA;
        cnt_nxt   = '0;
      end
      ST_MULA: begin
        if (cnt_r == CNT_W'(GAIN_DIGITS - 1)) begin
          state_nxt = ST_LDB;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LDB: begin
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        if (cnt_r == CNT_W'(DIFF_DIGITS - 1)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      carrier_phase_r <= '0;
      clip_r          <= CLIP_LEVEL_RST;
      mono_gain_r     <= MONO_GAIN_RST;
      stereo_gain_r   <= STEREO_GAIN_RST;
      pilot_r         <= PILOT_OFFSET_RST;
      phase_step_r    <= PHASE_STEP_RST;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      carrier_phase_r <= carrier_phase_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLIP_LEVEL:   clip_r        <= cfg_wdata[GAIN_W-1:0];
          REG_MONO_GAIN:    mono_gain_r   <= cfg_wdata[GAIN_W-1:0];
          REG_STEREO_GAIN:  stereo_gain_r <= cfg_wdata[GAIN_W-1:0];
          REG_PILOT_OFFSET: pilot_r       <= $signed(cfg_wdata[AUDIO_W-1:0]);
          REG_PHASE_STEP:   phase_step_r  <= cfg_wdata[STEP_W-1:0];
          default: ;        // unknown index: dropped
        endcase
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r    <= $signed(in_tdata[15:0]);
      right_r   <= $signed(in_tdata[31:16]);
      carrier_r <= rom_carrier;   // sample read before the phase advances
    end
    if (state_r == ST_PREP) begin
      d_neg_r <= diff_c[DIFF_W-1];
      d_mag_r <= diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
    end
    if (load_out) begin
      out_data_r <= q_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (carrier_phase_r == $past(phase_sum)))
    else $error("carrier phase did not advance by one step on a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && state_r == ST_FIN) |=>
      (state_r == ST_FIN && $stable(out_data_r)))
    else $error("pending result overwritten by the next one");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the finish step");

  a_car_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP) |-> (carrier_r <= CAR_MAX && carrier_r >= -CAR_MAX))
    else $error("carrier outside table amplitude");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import psmpx_pkg::*;

  // Register indexes past the last real register; writes there must be dropped.
  localparam int SPARE_REG_LO = 5;
  localparam int SPARE_REG_HI = (1 << CFG_IDX_W) - 1;
  // Stop even if the block hangs; the slowest legal run is far below this.
  localparam int CYCLE_LIMIT  = 600000;
  // Settle time after the block has drained, before registers are written.
  localparam int SETTLE_CYCLES = 25;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int HALF_PHASE    = 110;

  typedef struct packed {
    logic [AUDIO_W-1:0] right;
    logic [AUDIO_W-1:0] left;
  } lr_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;    // [15:0] left_sample, [31:16] right_sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // [15:0] mpx_sample
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  polar_stereo_mpx_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies, carrier phase, sine table.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]         clip_level_q   = CLIP_LEVEL_RST;
  logic [GAIN_W-1:0]         mono_gain_q    = MONO_GAIN_RST;
  logic [GAIN_W-1:0]         stereo_gain_q  = STEREO_GAIN_RST;
  logic signed [AUDIO_W-1:0] pilot_offset_q = PILOT_OFFSET_RST;
  logic [STEP_W-1:0]         phase_step_q   = PHASE_STEP_RST;
  logic [31:0]               carrier_phase  = '0;
  longint                    subcarrier_lut [1024];

  lr_pair_t    pending_pairs [$];   // requests not yet offered to the block
  logic [15:0] mpx_expected [$];    // composite samples still owed by the block

  int unsigned items_total  = 0;    // requests queued so far
  int unsigned results_seen = 0;    // results taken from the block so far
  int          fail_count   = 0;
  int unsigned cycle_count  = 0;

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  logic rx_hold_armed = 1'b0;
  logic rx_hold_done  = 1'b0;
  int  rx_hold_left  = 0;

  // Subcarrier amplitude at table entry k: quarter wave from a Q30 Taylor series,
  // mirrored for the second quarter, negated for the second half.
  function automatic longint subcarrier_level(int k);
    int unsigned taylor_div [6] = '{156, 110, 72, 42, 20, 6};
    logic [63:0] one, j, x, x2, acc, s, mag;
    int          kk;
    bit          neg;
    one = 64'd1 << 30;
    neg = (k >= 512);
    kk  = neg ? k - 512 : k;
    j   = (kk > 256) ? 64'(512 - kk) : 64'(kk);
    x   = (TWO_PI_Q30 * j) >> 10;
    x2  = (x * x) >> 30;
    acc = one;
    foreach (taylor_div[i]) begin
      acc = one - ((x2 * acc) >> 30) / 64'(taylor_div[i]);
    end
    s   = (x * acc) >> 30;
    mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Composite sample for one L/R pair at a given subcarrier value.
  function automatic logic [15:0] mpx_from_pair(logic [15:0] left_raw,
                                                logic [15:0] right_raw,
                                                longint carrier);
    longint lim, l, r, mono_term, diff_term, acc, q;
    lim = longint'(clip_level_q);
    l   = longint'($signed(left_raw));
    r   = longint'($signed(right_raw));
    if (l > lim) l = lim;
    if (l < -lim) l = -lim;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    mono_term = (l + r) * longint'(mono_gain_q) * 64'sd32768;
    diff_term = (l - r + 2 * longint'(pilot_offset_q)) * carrier * longint'(stereo_gain_q);
    // round half up at 2^31, floor via arithmetic shift
    acc = mono_term + diff_term + 64'sd1073741824;
    q   = acc >>> 31;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void shadow_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_CLIP_LEVEL:   clip_level_q   = val[GAIN_W-1:0];
      REG_MONO_GAIN:    mono_gain_q    = val[GAIN_W-1:0];
      REG_STEREO_GAIN:  stereo_gain_q  = val[GAIN_W-1:0];
      REG_PILOT_OFFSET: pilot_offset_q = val[AUDIO_W-1:0];
      REG_PHASE_STEP:   phase_step_q   = val[STEP_W-1:0];
      default: ;  // unused index, block ignores it
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes pairs from the pending queue, predicts on each accepted request.
  // ---------------------------------------------------------------------------
  lr_pair_t next_pair;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid     <= 1'b0;
      carrier_phase = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        // ROM read uses the phase before this request's advance
        mpx_expected.push_back(mpx_from_pair(in_tdata[15:0], in_tdata[31:16],
                                             subcarrier_lut[carrier_phase[31:22]]));
        carrier_phase = carrier_phase + phase_step_q;
      end
      // only change the offer when nothing is held, or it was just taken
      if (!in_tvalid || in_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          in_tdata  <= {next_pair.right, next_pair.left};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest expectation, drives ready.
  // ---------------------------------------------------------------------------
  logic [15:0] mpx_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mpx_expected.size() == 0) begin
          $error("mpx_sample: no result expected, got %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          mpx_want = mpx_expected.pop_front();
          if (out_tdata !== mpx_want) begin
            $error("mpx_sample: expected %0d, got %0d", $signed(mpx_want),
                   $signed(out_tdata));
            fail_count++;
          end
        end
        results_seen++;
      end
      out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off, counted here once the stimulus arms it.
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_armed && !rx_hold_done) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_pair(logic [15:0] l, logic [15:0] r);
    lr_pair_t p;
    p.left  = l;
    p.right = r;
    pending_pairs.push_back(p);
    items_total++;
  endtask

  // Full-range values and values inside the clip range, with weight on the clip edges and the rails.
  function automatic logic [15:0] audio_sample_draw();
    int lim, v;
    lim = int'(clip_level_q);
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(65535));
      4, 5, 6:    v = int'($urandom_range(2 * lim)) - lim;
      7: begin
        case ($urandom_range(4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = lim + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[15:0];
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_register(idx, val);
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (results_seen < items_total) begin
      @(posedge clk);
    end
  endtask

  // Random register set; sometimes with junk above the register width.
  task automatic random_config();
    logic [31:0] v;
    v = {17'd0, 15'($urandom_range(32767))};
    if ($urandom_range(5) == 0) v[14:0] = '0;
    if ($urandom_range(5) == 0) v[14:0] = '1;
    if ($urandom_range(1)) v[31:15] = 17'($urandom);
    write_reg(REG_CLIP_LEVEL, v);
    v = $urandom;
    write_reg(REG_MONO_GAIN, $urandom_range(1) ? v : {17'd0, v[14:0]});
    v = $urandom;
    write_reg(REG_STEREO_GAIN, $urandom_range(1) ? v : {17'd0, v[14:0]});
    v = $urandom;
    write_reg(REG_PILOT_OFFSET, $urandom_range(1) ? v : {16'd0, v[15:0]});
    write_reg(REG_PHASE_STEP, $urandom);
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(SPARE_REG_HI, SPARE_REG_LO)), $urandom);
    end
    close_writes();
  endtask

  initial begin
    int lim;
    for (int k = 0; k < 1024; k++) begin
      subcarrier_lut[k] = subcarrier_level(k);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        // block must be empty before touching registers
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
          1: begin
            // all maxima; wide values keep only their low bits
            write_reg(REG_CLIP_LEVEL, 32'hFFFF_FFFF);
            write_reg(REG_MONO_GAIN, {17'd0, 15'h7FFF});
            write_reg(REG_STEREO_GAIN, 32'hFFFF_FFFF);
            write_reg(REG_PILOT_OFFSET, 32'h0000_7FFF);
            write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
            for (int i = SPARE_REG_LO; i <= SPARE_REG_HI; i++) begin
              write_reg(CFG_IDX_W'(i), $urandom);
            end
            close_writes();
          end
          2: begin
            // clip level of zero (junk in upper bits), most negative pilot,
            // frozen phase
            write_reg(REG_CLIP_LEVEL, 32'h1234_8000);
            write_reg(REG_MONO_GAIN, 32'd0);
            write_reg(REG_STEREO_GAIN, {17'd0, 15'h7FFF});
            write_reg(REG_PILOT_OFFSET, 32'hFFFF_8000);
            write_reg(REG_PHASE_STEP, 32'd0);
            close_writes();
          end
          default: random_config();
        endcase
      end

      // idle mix per phase: none, sender idles, receiver stalls, both a little
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      // receiver backs off while the sender keeps pushing
      if (phase == 4) rx_hold_armed = 1'b1;

      // rails and crossed rails
      queue_pair(16'h7FFF, 16'h7FFF);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h7FFF, 16'h8000);
      queue_pair(16'h8000, 16'h7FFF);
      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'hFFFF, 16'h0001);
      if (phase == 0) begin
        // alternating bit patterns, then samples on and around the clip edge
        lim = int'(clip_level_q);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'(lim), 16'(-lim));
        queue_pair(16'(lim + 1), 16'(-lim - 1));
        queue_pair(16'(lim - 1), 16'(lim + 1));
        queue_pair(16'(-lim), 16'(-lim + 1));
        for (int n = 0; n < 8; n++) begin
          queue_pair(audio_sample_draw(), audio_sample_draw());
        end
      end

      for (int n = 0; n < HALF_PHASE; n++) begin
        queue_pair(audio_sample_draw(), audio_sample_draw());
      end
      // sender stops until the block has drained, then resumes
      wait_all_results();
      for (int n = 0; n < HALF_PHASE; n++) begin
        queue_pair(audio_sample_draw(), audio_sample_draw());
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && mpx_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
